// ===== design/mpe_pkg.sv =====
package mpe_pkg;

    localparam int MAX_SIZE      = 8;
    localparam int MAX_DEGREE    = 15;
    localparam int FRACTION_BITS = 16;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int IDX_W  = $clog2(MAX_SIZE);
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int CNT_W  = $clog2(MAX_SIZE * MAX_SIZE + 1);
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int CCNT_W = $clog2(MAX_DEGREE + 2);

    // cell pipeline depth and sequencer waits
    localparam int CELL_LAT     = 3;
    localparam int DRAIN_CYCLES = CELL_LAT * MAX_SIZE + 3;
    localparam int SCALE_CYCLES = 5;
    localparam int WAIT_W       = $clog2(DRAIN_CYCLES + 1);

    localparam logic [1:0] REG_MATRIX_SIZE = 2'd0;
    localparam logic [1:0] REG_POLY_DEGREE = 2'd1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SETUP,
        S_INIT,
        S_KBEGIN,
        S_PCAP,
        S_PISSUE,
        S_PDRAIN,
        S_SCAP,
        S_SCALE,
        S_SWAIT,
        S_OCAP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         col;
        logic signed [ACC_W-1:0]  acc;
    } t_link;

    typedef struct packed {
        logic [IDX_W-1:0]         size_m1;
        logic [IDX_W-1:0]         row;
        logic                     cap;
        logic                     init;
        logic                     scale;
        logic                     rd;
        logic                     w_en;
        logic                     w_src;
        logic [IDX_W-1:0]         w_row;
        logic [IDX_W-1:0]         w_col;
        logic signed [DATA_W-1:0] w_val;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     sat;
    } t_sat;

    // floor(a / 2^FRACTION_BITS), saturated to DATA_W bits
    function automatic t_sat shift_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        t_sat r;
        s = a >>> FRACTION_BITS;
        if ((&s[ACC_W-1:DATA_W-1]) || !(|s[ACC_W-1:DATA_W-1])) begin
            r.val = s[DATA_W-1:0];
            r.sat = 1'b0;
        end else begin
            r.val = s[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            r.sat = 1'b1;
        end
        return r;
    endfunction

    function automatic t_sat add_sat(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        t_sat r;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] == s[DATA_W-1]) begin
            r.val = s[DATA_W-1:0];
            r.sat = 1'b0;
        end else begin
            r.val = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== design/mpe_cell.sv =====
// One column cell: holds source row, power column and sum column of its index.
module mpe_cell (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [mpe_pkg::IDX_W-1:0]               i_index,
    input  mpe_pkg::t_cell_ctl                      i_ctl,
    input  logic signed [mpe_pkg::DATA_W-1:0]       i_coef,
    input  mpe_pkg::t_link                          i_link,
    output mpe_pkg::t_link                          o_link,
    output logic signed [mpe_pkg::DATA_W-1:0]       o_sum,
    output logic                                    o_sat
);

    logic signed [mpe_pkg::DATA_W-1:0] r_srow [mpe_pkg::MAX_SIZE];
    logic signed [mpe_pkg::DATA_W-1:0] r_pcol [mpe_pkg::MAX_SIZE];
    logic signed [mpe_pkg::DATA_W-1:0] r_scol [mpe_pkg::MAX_SIZE];

    logic signed [mpe_pkg::DATA_W-1:0] r_p;
    logic signed [mpe_pkg::DATA_W-1:0] r_s;
    logic signed [mpe_pkg::PROD_W-1:0] r_prod;
    logic signed [mpe_pkg::DATA_W-1:0] r_term;
    logic                              r_tsat;
    logic signed [mpe_pkg::DATA_W-1:0] r_sum_rd;
    logic signed [mpe_pkg::DATA_W-1:0] r_out;
    mpe_pkg::t_link                    r_l1;
    mpe_pkg::t_link                    r_l2;
    mpe_pkg::t_link                    r_l3;
    logic                              r_sc1;
    logic                              r_sc2;
    logic                              r_sc3;
    logic                              r_sat;

    logic                              w_active;
    logic signed [mpe_pkg::DATA_W-1:0] w_op;
    mpe_pkg::t_sat                     w_term;
    mpe_pkg::t_sat                     w_add;

    assign w_active = (i_index <= i_ctl.size_m1);
    assign w_op     = r_sc1 ? i_coef : r_s;
    assign w_term   = mpe_pkg::shift_sat(mpe_pkg::ACC_W'(r_prod));
    assign w_add    = mpe_pkg::add_sat(r_sum_rd, r_term);

    // local stores and datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.w_en && (i_ctl.w_col == i_index)) begin
            r_pcol[i_ctl.w_row] <= i_ctl.w_val;
        end
        if (i_ctl.w_en && i_ctl.w_src && (i_ctl.w_row == i_index)) begin
            r_srow[i_ctl.w_col] <= i_ctl.w_val;
        end
        if (i_ctl.cap) begin
            r_p <= r_pcol[i_ctl.row];
        end
        r_s    <= r_srow[i_link.col];
        r_prod <= r_p * w_op;
        if (r_sc2) begin
            r_term   <= w_term.val;
            r_tsat   <= w_term.sat;
            r_sum_rd <= r_scol[i_ctl.row];
        end
        if (r_sc3) begin
            r_scol[i_ctl.row] <= w_add.val;
        end else if (i_ctl.init) begin
            r_scol[i_ctl.row] <= (i_ctl.row == i_index) ? i_coef : '0;
        end
        if (i_ctl.rd) begin
            r_out <= r_scol[i_ctl.row];
        end
    end

    // partial sums step one cell along the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1.valid <= 1'b0;
            r_l2.valid <= 1'b0;
            r_l3.valid <= 1'b0;
            r_sc1      <= 1'b0;
            r_sc2      <= 1'b0;
            r_sc3      <= 1'b0;
            r_sat      <= 1'b0;
        end else begin
            r_l1       <= i_link;
            r_l2       <= r_l1;
            r_l3.valid <= r_l2.valid;
            r_l3.col   <= r_l2.col;
            r_l3.acc   <= r_l2.acc + (w_active ? mpe_pkg::ACC_W'(r_prod) : '0);
            r_sc1      <= i_ctl.scale;
            r_sc2      <= r_sc1;
            r_sc3      <= r_sc2;
            r_sat      <= r_sc3 && w_active && (r_tsat || w_add.sat);
        end
    end

    assign o_link = r_l3;
    assign o_sum  = r_out;
    assign o_sat  = r_sat;

endmodule

// ===== design/matrix_polynomial_evaluator.sv =====
// Results: once the last load transaction is taken the evaluation runs; n results (n = size)
// then leave per row, one per cycle while the output is not stalled, after a read state
// (S_OCAP) for each row.
// Throughput: one evaluation at a time; loading takes one transaction per cycle and
// is held off while an evaluation runs, set by the row-serial walk of the cell chain.
// Reset (synchronous, active low) sets size 1, degree 0, clears load counts; stores keep no reset.
module matrix_polynomial_evaluator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [1:0]                          i_cfg_index,
    input  logic [3:0]                          i_cfg_data,
    // load channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic signed [mpe_pkg::DATA_W-1:0]   i_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mpe_pkg::DATA_W-1:0]   o_result_value,
    output logic                                o_last_flag,
    output logic                                o_saturated
);

    // sequencer state
    mpe_pkg::t_state                    r_state;
    mpe_pkg::t_state                    n_state;

    // configuration, held as size minus one and clamped degree
    logic [mpe_pkg::IDX_W-1:0]          r_size_m1;
    logic [mpe_pkg::DEG_W-1:0]          r_deg;

    // load bookkeeping
    logic [mpe_pkg::CNT_W-1:0]          r_ecnt;
    logic [mpe_pkg::CCNT_W-1:0]         r_ccnt;
    logic [mpe_pkg::IDX_W-1:0]          r_lr;
    logic [mpe_pkg::IDX_W-1:0]          r_lc;

    // evaluation walk
    logic [mpe_pkg::DEG_W-1:0]          r_k;
    logic [mpe_pkg::IDX_W-1:0]          r_row;
    logic [mpe_pkg::IDX_W-1:0]          r_col;
    logic [mpe_pkg::WAIT_W-1:0]         r_wait;
    logic                               r_ovf;

    // coefficient store, registered read
    logic signed [mpe_pkg::DATA_W-1:0]  r_cmem [mpe_pkg::MAX_DEGREE+1];
    logic signed [mpe_pkg::DATA_W-1:0]  r_coef;

    // chain tail: shift and saturate each finished dot product
    logic                               r_fin_v;
    logic [mpe_pkg::IDX_W-1:0]          r_fin_col;
    logic signed [mpe_pkg::DATA_W-1:0]  r_fin_val;
    logic                               r_fin_sat;

    // output register
    logic                               r_ovalid;
    logic signed [mpe_pkg::DATA_W-1:0]  r_oval;
    logic                               r_olast;
    logic                               r_osat;

    logic [mpe_pkg::IDX_W:0]            w_n;
    logic [mpe_pkg::CNT_W-1:0]          w_cells;
    logic                               w_in_acc;
    logic                               w_el_wr;
    logic                               w_cf_wr;
    logic                               w_e_full;
    logic                               w_c_full;
    logic                               w_start;
    logic                               w_row_last;
    logic                               w_col_last;
    logic                               w_out_adv;
    logic                               w_drain_end;
    logic                               w_swait_end;
    logic                               w_cfg_hit;
    logic                               w_any_sat;
    mpe_pkg::t_sat                      w_fin;
    mpe_pkg::t_cell_ctl                 w_ctl;
    mpe_pkg::t_link                     w_link [mpe_pkg::MAX_SIZE+1];
    logic signed [mpe_pkg::DATA_W-1:0]  w_sum  [mpe_pkg::MAX_SIZE];
    logic [mpe_pkg::MAX_SIZE-1:0]       w_sat;

    assign w_n     = {1'b0, r_size_m1} + 1'b1;
    assign w_cells = mpe_pkg::CNT_W'(w_n) * mpe_pkg::CNT_W'(w_n);

    // loading: inputs are only taken between evaluations
    assign o_stall   = (r_state != mpe_pkg::S_LOAD);
    assign w_in_acc  = i_valid && !o_stall;
    assign w_el_wr   = w_in_acc && !i_command && (r_ecnt < w_cells);
    assign w_cf_wr   = w_in_acc && i_command && (r_ccnt <= {1'b0, r_deg});
    assign w_e_full  = w_el_wr ? ((r_ecnt + 1'b1) == w_cells) : (r_ecnt == w_cells);
    assign w_c_full  = w_cf_wr ? ((r_ccnt + 1'b1) == ({1'b0, r_deg} + 1'b1))
                               : (r_ccnt == ({1'b0, r_deg} + 1'b1));
    assign w_start   = (w_el_wr || w_cf_wr) && w_e_full && w_c_full;
    assign w_cfg_hit = i_cfg_wr_en && ((i_cfg_index == mpe_pkg::REG_MATRIX_SIZE) ||
                                       (i_cfg_index == mpe_pkg::REG_POLY_DEGREE));

    assign w_row_last  = (r_row == r_size_m1);
    assign w_col_last  = (r_col == r_size_m1);
    assign w_out_adv   = !r_ovalid || !i_stall;
    assign w_drain_end = (r_wait == mpe_pkg::WAIT_W'(mpe_pkg::DRAIN_CYCLES - 1));
    assign w_swait_end = (r_wait == mpe_pkg::WAIT_W'(mpe_pkg::SCALE_CYCLES - 1));
    assign w_any_sat   = |w_sat;
    assign w_fin       = mpe_pkg::shift_sat(w_link[mpe_pkg::MAX_SIZE].acc);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpe_pkg::S_LOAD: begin
                if (w_start) n_state = mpe_pkg::S_SETUP;
            end
            mpe_pkg::S_SETUP:  n_state = mpe_pkg::S_INIT;
            mpe_pkg::S_INIT: begin
                if (w_row_last) begin
                    n_state = (r_deg == '0) ? mpe_pkg::S_OCAP : mpe_pkg::S_KBEGIN;
                end
            end
            mpe_pkg::S_KBEGIN: begin
                n_state = (r_k == mpe_pkg::DEG_W'(1)) ? mpe_pkg::S_SCAP : mpe_pkg::S_PCAP;
            end
            mpe_pkg::S_PCAP:   n_state = mpe_pkg::S_PISSUE;
            mpe_pkg::S_PISSUE: begin
                if (w_col_last) n_state = mpe_pkg::S_PDRAIN;
            end
            mpe_pkg::S_PDRAIN: begin
                if (w_drain_end) n_state = w_row_last ? mpe_pkg::S_SCAP : mpe_pkg::S_PCAP;
            end
            mpe_pkg::S_SCAP:   n_state = mpe_pkg::S_SCALE;
            mpe_pkg::S_SCALE:  n_state = mpe_pkg::S_SWAIT;
            mpe_pkg::S_SWAIT: begin
                if (w_swait_end) begin
                    if (!w_row_last) begin
                        n_state = mpe_pkg::S_SCAP;
                    end else begin
                        n_state = (r_k == r_deg) ? mpe_pkg::S_OCAP : mpe_pkg::S_KBEGIN;
                    end
                end
            end
            mpe_pkg::S_OCAP:   n_state = mpe_pkg::S_OUT;
            mpe_pkg::S_OUT: begin
                if (w_out_adv && w_col_last) begin
                    n_state = w_row_last ? mpe_pkg::S_LOAD : mpe_pkg::S_OCAP;
                end
            end
            default:           n_state = mpe_pkg::S_LOAD;
        endcase
    end

    // cell controls
    always_comb begin
        w_ctl.size_m1 = r_size_m1;
        w_ctl.row     = r_row;
        w_ctl.cap     = (r_state == mpe_pkg::S_PCAP) || (r_state == mpe_pkg::S_SCAP);
        w_ctl.init    = (r_state == mpe_pkg::S_INIT);
        w_ctl.scale   = (r_state == mpe_pkg::S_SCALE);
        w_ctl.rd      = (r_state == mpe_pkg::S_OCAP);
        w_ctl.w_en    = w_el_wr || r_fin_v;
        w_ctl.w_src   = w_el_wr;
        w_ctl.w_row   = w_el_wr ? r_lr : r_row;
        w_ctl.w_col   = w_el_wr ? r_lc : r_fin_col;
        w_ctl.w_val   = w_el_wr ? i_value : r_fin_val;
        // feed one column of the current row into the head of the chain
        w_link[0].valid = (r_state == mpe_pkg::S_PISSUE);
        w_link[0].col   = r_col;
        w_link[0].acc   = '0;
    end

    // row of cells; cell g holds column g of the power and sum matrices
    for (genvar g = 0; g < mpe_pkg::MAX_SIZE; g++) begin : g_cell
        mpe_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (mpe_pkg::IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_coef  (r_coef),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_sum   (w_sum[g]),
            .o_sat   (w_sat[g])
        );
    end

    // coefficient store, tail stage payload and output data
    always_ff @(posedge i_clk) begin
        if (w_cf_wr) begin
            r_cmem[r_ccnt[mpe_pkg::DEG_W-1:0]] <= i_value;
        end
        r_coef    <= r_cmem[r_k];
        r_fin_col <= w_link[mpe_pkg::MAX_SIZE].col;
        r_fin_val <= w_fin.val;
        r_fin_sat <= w_fin.sat;
        if (r_state == mpe_pkg::S_OUT && w_out_adv) begin
            r_oval  <= w_sum[r_col];
            r_olast <= w_row_last && w_col_last;
            r_osat  <= r_ovf;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mpe_pkg::S_LOAD;
            r_size_m1 <= '0;
            r_deg     <= '0;
            r_ecnt    <= '0;
            r_ccnt    <= '0;
            r_lr      <= '0;
            r_lc      <= '0;
            r_k       <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_wait    <= '0;
            r_ovf     <= 1'b0;
            r_fin_v   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin_v <= w_link[mpe_pkg::MAX_SIZE].valid;

            // load counts: a size or degree register write restarts loading, a start clears them
            if (w_cfg_hit || w_start) begin
                r_ecnt <= '0;
                r_ccnt <= '0;
                r_lr   <= '0;
                r_lc   <= '0;
            end else begin
                if (w_el_wr) begin
                    r_ecnt <= r_ecnt + 1'b1;
                    if (r_lc == r_size_m1) begin
                        r_lc <= '0;
                        r_lr <= r_lr + 1'b1;
                    end else begin
                        r_lc <= r_lc + 1'b1;
                    end
                end
                if (w_cf_wr) begin
                    r_ccnt <= r_ccnt + 1'b1;
                end
            end

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    mpe_pkg::REG_MATRIX_SIZE: begin
                        if (i_cfg_data == '0) begin
                            r_size_m1 <= '0;
                        end else if (i_cfg_data > 4'(mpe_pkg::MAX_SIZE)) begin
                            r_size_m1 <= mpe_pkg::IDX_W'(mpe_pkg::MAX_SIZE - 1);
                        end else begin
                            r_size_m1 <= mpe_pkg::IDX_W'(i_cfg_data - 1'b1);
                        end
                    end
                    mpe_pkg::REG_POLY_DEGREE: begin
                        if (i_cfg_data > 4'(mpe_pkg::MAX_DEGREE)) begin
                            r_deg <= mpe_pkg::DEG_W'(mpe_pkg::MAX_DEGREE);
                        end else begin
                            r_deg <= mpe_pkg::DEG_W'(i_cfg_data);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // walk counters
            unique case (r_state)
                mpe_pkg::S_LOAD: begin
                    r_row <= '0;
                    r_k   <= '0;
                end
                mpe_pkg::S_INIT: begin
                    r_row <= w_row_last ? '0 : r_row + 1'b1;
                    if (w_row_last) r_k <= mpe_pkg::DEG_W'(1);
                end
                mpe_pkg::S_PCAP:   r_col <= '0;
                mpe_pkg::S_PISSUE: r_col <= r_col + 1'b1;
                mpe_pkg::S_PDRAIN: begin
                    if (w_drain_end) r_row <= w_row_last ? '0 : r_row + 1'b1;
                end
                mpe_pkg::S_SWAIT: begin
                    if (w_swait_end) begin
                        r_row <= w_row_last ? '0 : r_row + 1'b1;
                        if (w_row_last && (r_k != r_deg)) r_k <= r_k + 1'b1;
                    end
                end
                mpe_pkg::S_OCAP:   r_col <= '0;
                mpe_pkg::S_OUT: begin
                    if (w_out_adv) begin
                        r_col <= r_col + 1'b1;
                        if (w_col_last) r_row <= r_row + 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // hold a wait count only while draining the chain or a scale step
            if ((r_state == mpe_pkg::S_PDRAIN && !w_drain_end) ||
                (r_state == mpe_pkg::S_SWAIT && !w_swait_end)) begin
                r_wait <= r_wait + 1'b1;
            end else begin
                r_wait <= '0;
            end

            // sticky saturation flag for this evaluation
            if (r_state == mpe_pkg::S_SETUP) begin
                r_ovf <= 1'b0;
            end else if ((r_fin_v && r_fin_sat) || w_any_sat) begin
                r_ovf <= 1'b1;
            end

            // output register: advance when empty or taken, drop when taken
            if (r_state == mpe_pkg::S_OUT && w_out_adv) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_oval;
    assign o_last_flag    = r_olast;
    assign o_saturated    = r_osat;

`ifndef SYNTH
    a_fin_in_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_v |-> (r_state == mpe_pkg::S_PISSUE || r_state == mpe_pkg::S_PDRAIN))
        else $error("chain result outside a product pass");
    a_ecnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= w_cells)
        else $error("element count beyond matrix size");
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> (r_ecnt == '0 && r_ccnt == '0))
        else $error("register write did not restart loading");
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_el_wr || w_cf_wr) |-> (r_state == mpe_pkg::S_LOAD))
        else $error("load while evaluating");
`endif

endmodule
